// ===== rtl/ptet_pkg.sv =====
// Shared types and codes for the periodic timer event table.
package ptet_pkg;

	// Action codes of an input item
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_REG    = 2'd1;
	localparam logic [1:0] ACT_ARM    = 2'd2;
	localparam logic [1:0] ACT_DISARM = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [15:0] signal_code;
		logic [7:0]  target_id;
		logic [31:0] first_delay;
		logic [31:0] reload_period;
	} ptet_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  out_slot;
		logic [15:0] out_signal;
		logic [7:0]  out_target;
		logic        last;
	} ptet_out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic flush;
	} ptet_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_end;
	} ptet_stat_t;

endpackage

// ===== rtl/ptet_ctrl.sv =====
// Controller state machine: sequences single actions and tick scans.
module ptet_ctrl
	import ptet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  ptet_stat_t stat,
	output ptet_cmd_t  cmd,
	output logic       busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Decode state into datapath commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = (action == ACT_TICK) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.scan_end) begin
					cmd.flush = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/ptet_dp.sv =====
// Datapath: slot storage, scan counter, pending fired result and result register.
module ptet_dp
	import ptet_pkg::*;
#(
	parameter int NUM_SLOTS    = 10,
	parameter int COUNT_WIDTH  = 32,
	parameter int SIGNAL_WIDTH = 16,
	parameter int TARGET_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ptet_in_t   item,
	input  ptet_cmd_t  cmd,
	output ptet_stat_t stat,
	output logic       strobe,
	output ptet_out_t  result
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	// Slot storage
	logic [COUNT_WIDTH-1:0]  count_mem  [NUM_SLOTS];
	logic [COUNT_WIDTH-1:0]  reload_mem [NUM_SLOTS];
	logic [SIGNAL_WIDTH-1:0] sig_mem    [NUM_SLOTS];
	logic [TARGET_WIDTH-1:0] tgt_mem    [NUM_SLOTS];

	ptet_in_t         item_q;
	logic [CW-1:0]    used_q;
	logic [CW-1:0]    idx_q;
	logic             pend_vld_q;
	ptet_out_t        pend_q;
	logic             strobe_q;
	ptet_out_t        result_q;

	// Write port controls
	logic                   wr_cnt;
	logic                   wr_rel;
	logic                   wr_tag;
	logic [IW-1:0]          wr_idx;
	logic [COUNT_WIDTH-1:0] wr_cnt_val;
	logic [COUNT_WIDTH-1:0] wr_rel_val;

	logic                   emit;
	ptet_out_t              emit_res;
	logic                   set_pend;
	ptet_out_t              new_pend;
	logic                   used_inc;

	logic [IW-1:0]          rd_idx;
	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [COUNT_WIDTH-1:0] cnt_dec;
	logic [63:0]            delay_ext;
	logic [63:0]            period_ext;
	logic [31:0]            sig_ext;
	logic [15:0]            tgt_ext;
	logic [7:0]             idx_ext;
	logic [7:0]             used_ext;
	logic [7:0]             req_ext;
	logic                   table_full;
	logic                   bad_slot;

	assign rd_idx     = idx_q[IW-1:0];
	assign cnt_rd     = count_mem[rd_idx];
	assign cnt_dec    = cnt_rd - COUNT_WIDTH'(1);
	assign delay_ext  = 64'(item_q.first_delay);
	assign period_ext = 64'(item_q.reload_period);
	assign sig_ext    = 32'(sig_mem[rd_idx]);
	assign tgt_ext    = 16'(tgt_mem[rd_idx]);
	assign idx_ext    = 8'(idx_q);
	assign used_ext   = 8'(used_q);
	assign req_ext    = 8'(item_q.slot);
	assign table_full = (used_q >= CW'(NUM_SLOTS));
	assign bad_slot   = (req_ext >= used_ext);

	assign stat.scan_end = (idx_q >= used_q);

	// Decide writes and results for this cycle
	always_comb begin
		wr_cnt     = 1'b0;
		wr_rel     = 1'b0;
		wr_tag     = 1'b0;
		wr_idx     = rd_idx;
		wr_cnt_val = '0;
		wr_rel_val = '0;
		emit       = 1'b0;
		emit_res   = '0;
		set_pend   = 1'b0;
		new_pend   = '0;
		used_inc   = 1'b0;

		if (cmd.exec) begin
			emit          = 1'b1;
			emit_res.last = 1'b1;
			if (item_q.action == ACT_REG) begin
				if (table_full) begin
					emit_res.kind = KIND_ERROR;
				end else begin
					emit_res.kind     = KIND_ACK;
					emit_res.out_slot = used_ext[3:0];
					wr_idx            = used_q[IW-1:0];
					wr_cnt            = 1'b1;
					wr_rel            = 1'b1;
					wr_tag            = 1'b1;
					used_inc          = 1'b1;
				end
			end else begin
				emit_res.out_slot = item_q.slot;
				if (bad_slot) begin
					emit_res.kind = KIND_ERROR;
				end else begin
					emit_res.kind = KIND_ACK;
					wr_idx        = item_q.slot[IW-1:0];
					wr_cnt        = 1'b1;
					if (item_q.action == ACT_ARM) begin
						wr_cnt_val = delay_ext[COUNT_WIDTH-1:0];
						wr_rel     = 1'b1;
						wr_rel_val = period_ext[COUNT_WIDTH-1:0];
					end
				end
			end
		end

		if (cmd.step && (cnt_rd != '0)) begin
			wr_cnt = 1'b1;
			if (cnt_dec == '0) begin
				// Fired: reload and queue the result, pushing out any older one
				wr_cnt_val          = reload_mem[rd_idx];
				set_pend            = 1'b1;
				new_pend.kind       = KIND_FIRED;
				new_pend.out_slot   = idx_ext[3:0];
				new_pend.out_signal = sig_ext[15:0];
				new_pend.out_target = tgt_ext[7:0];
				new_pend.last       = 1'b0;
				if (pend_vld_q) begin
					emit     = 1'b1;
					emit_res = pend_q;
				end
			end else begin
				wr_cnt_val = cnt_dec;
			end
		end

		if (cmd.flush && pend_vld_q) begin
			emit          = 1'b1;
			emit_res      = pend_q;
			emit_res.last = 1'b1;
		end
	end

	// Slot storage writes
	always_ff @(posedge clk) begin
		if (wr_cnt) begin
			count_mem[wr_idx] <= wr_cnt_val;
		end
		if (wr_rel) begin
			reload_mem[wr_idx] <= wr_rel_val;
		end
		if (wr_tag) begin
			sig_mem[wr_idx] <= item_q.signal_code[SIGNAL_WIDTH-1:0];
			tgt_mem[wr_idx] <= item_q.target_id[TARGET_WIDTH-1:0];
		end
	end

	// Hold the accepted item and the pending fired result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (set_pend) begin
			pend_q <= new_pend;
		end
		if (emit) begin
			result_q <= emit_res;
		end
	end

	// Control registers: fill count, scan index, pending flag, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			idx_q      <= '0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (used_inc) begin
				used_q <= used_q + CW'(1);
			end
			if (cmd.load) begin
				idx_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + CW'(1);
				if (set_pend) begin
					pend_vld_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== rtl/periodic_time_event_table_core.sv =====
// Top level of the periodic timer event table.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done. Register, arm and disarm give one result, on strobe
// in the same cycle that busy falls. In a tick the scan visits one registered
// slot per cycle through the single countdown read, decrement and write-back
// path. Fired results come out during the scan in ascending slot order, each
// held back one fire so that last can be set on the final one; a tick where
// nothing fires gives no result. Each result is shown on strobe for exactly
// one cycle and cannot be stalled, so the receiver must take it in that cycle.
module periodic_time_event_table_core
	import ptet_pkg::*;
#(
	parameter int NUM_SLOTS    = 10,
	parameter int COUNT_WIDTH  = 32,
	parameter int SIGNAL_WIDTH = 16,
	parameter int TARGET_WIDTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ptet_in_t  item,
	output logic      strobe,
	output ptet_out_t result
);

	ptet_cmd_t  cmd;
	ptet_stat_t stat;

	// Sequence each transfer
	ptet_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Store slots and build results
	ptet_dp #(
		.NUM_SLOTS    (NUM_SLOTS),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SIGNAL_WIDTH (SIGNAL_WIDTH),
		.TARGET_WIDTH (TARGET_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule
